@@ src/fct_pkg.sv @@
// Shared types, widths and helpers for the frustum cull test unit.
// Used by every module in this folder; depends on nothing.
package fct_pkg;

    // Default number of clip planes held by the block
    localparam int NUM_PLANES_DEF = 6;

    // Field widths fixed by the item format
    localparam int COMP_W  = 16;
    localparam int Q16_W   = 32;
    localparam int INDEX_W = 3;
    localparam int OP_W    = 2;

    // Exact term widths: product, plane constant plus radius, pair sum, full sum
    localparam int PROD_W  = COMP_W + Q16_W;
    localparam int WSUM_W  = Q16_W + 1;
    localparam int PAIR_W  = PROD_W + 1;
    localparam int ACC_W   = PAIR_W + 1;
    localparam int FRAC_SH = COMP_W - 1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_BOX    = 2'd1,
        OP_SPHERE = 2'd2
    } opcode_t;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [Q16_W-1:0]  q16_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [WSUM_W-1:0] wsum_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
    } normal_t;

    // Per-stage load enables handed from the control in the top level to each lane
    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
    } adv_t;

    // Exact signed product of a Q1.15 component and a Q16.16 coordinate
    function automatic prod_t mul_nc(comp_t n, q16_t c);
        prod_t a;
        prod_t b;
        a = prod_t'(n);
        b = prod_t'(c);
        return a * b;
    endfunction

endpackage

@@ src/frustum_cull_test_unit.sv @@
// Frustum cull test unit: plane store, one test lane per plane, pipeline control.
// Depends on fct_pkg, fct_plane_file and fct_lane.
//
// Takes one item per clock while in_stall is low and gives one visibility bit per
// box or sphere query, after the three lane stages and the output register. A load
// writes one plane at its transfer edge and gives no result; a query taken in
// the next cycle already tests against it. Planes reset to zero, so queries read
// visible until planes are loaded. Each plane has its own lane (three products of
// 16 x 32 bits, then two rounds of adds); the lanes run side by side, and the
// final AND over all planes sits in the output register. Every stage holds its
// own valid bit, so bubbles close up under stall and the input keeps taking
// items while a finished result waits at the output.
module frustum_cull_test_unit #(
    parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [fct_pkg::OP_W-1:0]    opcode,
    input  logic [fct_pkg::INDEX_W-1:0] plane_index,
    input  fct_pkg::comp_t              normal_x,
    input  fct_pkg::comp_t              normal_y,
    input  fct_pkg::comp_t              normal_z,
    input  fct_pkg::q16_t               plane_offset,
    input  fct_pkg::q16_t               low_x,
    input  fct_pkg::q16_t               low_y,
    input  fct_pkg::q16_t               low_z,
    input  fct_pkg::q16_t               high_x,
    input  fct_pkg::q16_t               high_y,
    input  fct_pkg::q16_t               high_z,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        visible
);
    import fct_pkg::*;

    normal_t               normal [NUM_PLANES];
    q16_t                  offset [NUM_PLANES];
    logic [NUM_PLANES-1:0] behind;
    normal_t               wr_normal;
    adv_t                  adv;

    logic in_acc;
    logic is_box;
    logic is_query;
    logic is_load;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy_out;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic out_valid_reg;
    logic visible_reg;

    // Decode the incoming item
    always_comb
    begin
        is_box    = (opcode == OP_BOX);
        is_query  = (opcode == OP_BOX) || (opcode == OP_SPHERE);
        is_load   = (opcode == OP_LOAD);
        wr_normal = '{x: normal_x, y: normal_y, z: normal_z};
    end

    // Ready chain: a stage may load when empty or when it passes its item on
    always_comb
    begin
        rdy_out    = !out_valid_reg || !out_stall;
        rdy3       = !v3_reg || rdy_out;
        rdy2       = !v2_reg || rdy3;
        rdy1       = !v1_reg || rdy2;
        in_stall   = !rdy1;
        in_acc     = in_valid && rdy1;
        adv.s1_en  = in_acc && is_query;
        adv.s2_en  = rdy2 && v1_reg;
        adv.s3_en  = rdy3 && v2_reg;
    end

    fct_plane_file #(
        .NUM_PLANES (NUM_PLANES)
    ) u_plane_file (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (in_acc && is_load),
        .wr_index  (plane_index),
        .wr_normal (wr_normal),
        .wr_offset (plane_offset),
        .normal    (normal),
        .offset    (offset)
    );

    for (genvar g = 0; g < NUM_PLANES; g++)
    begin : g_lane
        fct_lane u_lane (
            .clk    (clk),
            .adv    (adv),
            .is_box (is_box),
            .normal (normal[g]),
            .offset (offset[g]),
            .low_x  (low_x),
            .low_y  (low_y),
            .low_z  (low_z),
            .high_x (high_x),
            .high_y (high_y),
            .high_z (high_z),
            .behind (behind[g])
        );
    end

    // Advance the valid bits; only queries enter the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid && is_query;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy_out)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    // Combine the plane tests into the result register
    always_ff @(posedge clk)
    begin
        if (rdy_out && v3_reg)
        begin
            visible_reg <= ~|behind;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;

    // Input stalls only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // A transfer fills stage one exactly when it is a query
    a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (v1_reg == $past(is_query)))
        else $error("stage one valid does not follow the accepted opcode");

    // A finished item moves to an empty output register at once
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("result did not reach the empty output register");

    // An item held in stage three while the output stalls stays there
    a_hold3: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && out_valid_reg && out_stall) |=> v3_reg)
        else $error("stage three item lost under stall");

endmodule

@@ src/fct_plane_file.sv @@
// Clip plane store: one normal and one offset register per plane.
// Depends on fct_pkg for the plane types.
module fct_plane_file #(
    parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [fct_pkg::INDEX_W-1:0]        wr_index,
    input  fct_pkg::normal_t                   wr_normal,
    input  fct_pkg::q16_t                      wr_offset,
    output fct_pkg::normal_t                   normal [NUM_PLANES],
    output fct_pkg::q16_t                      offset [NUM_PLANES]
);
    import fct_pkg::*;

    normal_t normal_reg [NUM_PLANES];
    q16_t    offset_reg [NUM_PLANES];

    // Write the addressed plane; an index beyond the store matches no entry and is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                normal_reg[i] <= '0;
                offset_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                if (wr_index == INDEX_W'(i))
                begin
                    normal_reg[i] <= wr_normal;
                    offset_reg[i] <= wr_offset;
                end
            end
        end
    end

    assign normal = normal_reg;
    assign offset = offset_reg;

endmodule

@@ src/fct_lane.sv @@
// One plane test lane: products, pair sums, final sum and sign, over three stages.
// Depends on fct_pkg for types, widths and the product helper.
module fct_lane (
    input  logic             clk,
    input  fct_pkg::adv_t    adv,
    input  logic             is_box,
    input  fct_pkg::normal_t normal,
    input  fct_pkg::q16_t    offset,
    input  fct_pkg::q16_t    low_x,
    input  fct_pkg::q16_t    low_y,
    input  fct_pkg::q16_t    low_z,
    input  fct_pkg::q16_t    high_x,
    input  fct_pkg::q16_t    high_y,
    input  fct_pkg::q16_t    high_z,
    output logic             behind
);
    import fct_pkg::*;

    q16_t  sel_x;
    q16_t  sel_y;
    q16_t  sel_z;
    wsum_t wsum;
    prod_t px_next;
    prod_t py_next;
    prod_t pz_next;
    prod_t base_next;
    pair_t a_next;
    pair_t b_next;
    acc_t  acc;

    prod_t px_reg;
    prod_t py_reg;
    prod_t pz_reg;
    prod_t base_reg;
    pair_t a_reg;
    pair_t b_reg;
    logic  behind_reg;

    // Pick the corner farthest along the normal for a box; the centre for a sphere
    always_comb
    begin
        sel_x = (is_box && !normal.x[COMP_W-1]) ? high_x : low_x;
        sel_y = (is_box && !normal.y[COMP_W-1]) ? high_y : low_y;
        sel_z = (is_box && !normal.z[COMP_W-1]) ? high_z : low_z;
        // Sphere folds the radius into the plane constant
        wsum  = is_box ? {offset[Q16_W-1], offset}
                       : ({offset[Q16_W-1], offset} + {high_x[Q16_W-1], high_x});
        px_next   = mul_nc(normal.x, sel_x);
        py_next   = mul_nc(normal.y, sel_y);
        pz_next   = mul_nc(normal.z, sel_z);
        base_next = {wsum, FRAC_SH'(0)};
    end

    // Add in pairs, then the final sum
    always_comb
    begin
        a_next = {px_reg[PROD_W-1], px_reg} + {py_reg[PROD_W-1], py_reg};
        b_next = {pz_reg[PROD_W-1], pz_reg} + {base_reg[PROD_W-1], base_reg};
        acc    = {a_reg[PAIR_W-1], a_reg} + {b_reg[PAIR_W-1], b_reg};
    end

    // Stage one: products and scaled constant
    always_ff @(posedge clk)
    begin
        if (adv.s1_en)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            pz_reg   <= pz_next;
            base_reg <= base_next;
        end
    end

    // Stage two: pair sums
    always_ff @(posedge clk)
    begin
        if (adv.s2_en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // Stage three: sign of the signed distance
    always_ff @(posedge clk)
    begin
        if (adv.s3_en)
        begin
            behind_reg <= acc[ACC_W-1];
        end
    end

    assign behind = behind_reg;

endmodule
